/* rtl/sobel_edge_magnitude_macros.svh */
// assertion helpers for the sobel edge magnitude module
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

// condition and consequence in the same cycle
`define SEM_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sobel edge magnitude check failed");

// consequence in the cycle after the condition
`define SEM_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sobel edge magnitude check failed");

`endif

/* rtl/sem_pkg.sv */
`default_nettype none
package sem_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_LINE   = 1024;
  localparam int COL_W      = $clog2(MAX_LINE);
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GRAD_W     = 12;
  localparam int SQ_W       = 20;
  localparam int SUM_W      = SQ_W + 1;
  localparam int RAD_W      = 16;
  localparam int ROOT_W     = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;

  localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = 11'd640;
  localparam logic [CNT_W-1:0] LINE_COUNT_RESET  = 16'd480;
  localparam logic [LEN_W-1:0] MIN_LENGTH        = 11'd3;
  localparam logic [CNT_W-1:0] MIN_COUNT         = 16'd3;
  localparam logic [PIX_W-1:0] MAG_MAX           = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [0:8][PIX_W-1:0] win_t;
  typedef logic [0:8][2:0] kern_t;

  // square root unit status
  typedef struct packed {
    logic busy;
    logic done;
  } root_status_t;

  // sobel kernels, row major, column 0 is the oldest
  localparam kern_t KERN_X = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2,
                               -3'sd1, 3'sd0, 3'sd1};
  localparam kern_t KERN_Y = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0, 3'sd0, 3'sd0,
                               3'sd1, 3'sd2, 3'sd1};

  // 3x3 weighted sum of a window
  function automatic logic signed [GRAD_W-1:0] sem_conv(input win_t w, input kern_t k);
    logic signed [GRAD_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + $signed({{(GRAD_W-PIX_W){1'b0}}, w[i]}) * GRAD_W'($signed(k[i]));
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

/* rtl/sem_isqrt.sv */
`default_nettype none
module sem_isqrt
  import sem_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  value,
  output logic      [ROOT_W-1:0] root,
  output root_status_t           status
);

  logic [RAD_W-1:0]  radicand;
  logic [ROOT_W-1:0] trial_bit;
  logic [ROOT_W-1:0] trial;
  logic [RAD_W-1:0]  trial_sq;

  // one result bit per cycle, msb first
  assign trial    = root | trial_bit;
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= '0;
      trial_bit <= '0;
    end else begin
      status.done <= status.busy & trial_bit[0];
      if (start) begin
        status.busy <= 1'b1;
        trial_bit   <= {1'b1, {(ROOT_W-1){1'b0}}};
      end else if (status.busy) begin
        status.busy <= ~trial_bit[0];
        trial_bit   <= trial_bit >> 1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      radicand <= value;
      root     <= '0;
    end else if (status.busy && trial_sq <= radicand) begin
      root <= trial;
    end
  end

endmodule
`default_nettype wire

/* rtl/sobel_edge_magnitude.sv */
// Sobel 3x3 gradient magnitude over a raster pixel stream. One pixel is taken
// per transfer; once two lines and two columns are buffered, each pixel that
// closes a full 3x3 window yields floor(sqrt(Gx^2+Gy^2)) saturated to 255, so a
// frame of line_count lines by line_length pixels gives (line_count-2) by
// (line_length-2) results, the last one flagged with end_of_frame. The two
// previous lines sit in one 1024 x 16 single port RAM read in the cycle before
// the write back; no clearing pass runs after reset. A border pixel ends after
// the window state; an interior pixel goes on through the 8-step bit-serial
// square root unit, which a saturating magnitude skips; a pending result in
// the output register does not stall the next pixel until its result is due.
// Writing either geometry register restarts the frame at line 0, column 0.
`default_nettype none
`include "sobel_edge_magnitude_macros.svh"
module sobel_edge_magnitude
  import sem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      pixel,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIX_W-1:0]      magnitude,
  output logic                       end_of_frame,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_WIN, S_SQ, S_SUM, S_ROOT, S_OUT} state_t;

  state_t state;

  logic [LEN_W-1:0] line_length;
  logic [CNT_W-1:0] line_count;
  logic [LEN_W-1:0] eff_len;
  logic [CNT_W-1:0] eff_cnt;
  logic [COL_W-1:0] column_count;
  logic [CNT_W-1:0] line_index;
  logic [COL_W-1:0] cur_col;
  logic [CNT_W-1:0] cur_row;
  logic [COL_W-1:0] col_start;
  logic [CNT_W-1:0] row_start;
  pix_t             pix_reg;
  pix_t             window_regs [6];

  // line store: upper byte two lines up, lower byte one line up
  logic [2*PIX_W-1:0] line_mem [MAX_LINE];
  logic [2*PIX_W-1:0] rd_data;
  pix_t               top;
  pix_t               mid;

  win_t                     win;
  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic signed [GRAD_W-1:0] gx_reg;
  logic signed [GRAD_W-1:0] gy_reg;
  logic signed [2*GRAD_W-1:0] prod_x;
  logic signed [2*GRAD_W-1:0] prod_y;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;
  logic [SUM_W-1:0]         sum;
  logic                     sat;
  logic                     produce;
  logic                     last_pos;
  logic                     eof_reg;
  pix_t                     mag_reg;
  logic                     out_load;
  logic                     in_xfer;
  logic                     cfg_restart;
  logic [LEN_W-1:0]         col_inc;
  logic [CNT_W:0]           row_inc;

  logic              root_start;
  logic [ROOT_W-1:0] root;
  root_status_t      root_status;

  // effective geometry
  always_comb begin
    if (line_length < MIN_LENGTH) begin
      eff_len = MIN_LENGTH;
    end else if (line_length > LEN_W'(MAX_LINE)) begin
      eff_len = LEN_W'(MAX_LINE);
    end else begin
      eff_len = line_length;
    end
    eff_cnt = (line_count < MIN_COUNT) ? MIN_COUNT : line_count;
  end

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign col_start = ({1'b0, column_count} >= eff_len) ? '0 : column_count;
  assign row_start = (line_index >= eff_cnt) ? '0 : line_index;
  assign cfg_restart = cfg_we &&
                       ((cfg_index == REG_LINE_LENGTH) || (cfg_index == REG_LINE_COUNT));

  // line store read at transfer, write back in the cycle after
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= line_mem[col_start];
    end
    if (state == S_WIN) begin
      line_mem[cur_col] <= {mid, pix_reg};
    end
  end

  assign top = rd_data[2*PIX_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];

  // window and gradients
  always_comb begin
    win = '{window_regs[0], window_regs[3], top,
            window_regs[1], window_regs[4], mid,
            window_regs[2], window_regs[5], pix_reg};
    gx  = sem_conv(win, KERN_X);
    gy  = sem_conv(win, KERN_Y);
  end

  assign produce  = (cur_row >= CNT_W'(2)) && (cur_col >= COL_W'(2));
  assign last_pos = (cur_row == eff_cnt - CNT_W'(1)) &&
                    ({1'b0, cur_col} == eff_len - LEN_W'(1));
  assign col_inc  = {1'b0, cur_col} + LEN_W'(1);
  assign row_inc  = {1'b0, cur_row} + (CNT_W+1)'(1);
  assign prod_x   = gx_reg * gx_reg;
  assign prod_y   = gy_reg * gy_reg;
  assign sum      = {1'b0, sq_x} + {1'b0, sq_y};
  assign sat      = (sum[SUM_W-1:RAD_W] != '0);
  assign root_start = (state == S_SUM) && !sat;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  sem_isqrt u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .value  (sum[RAD_W-1:0]),
    .root   (root),
    .status (root_status)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      line_length  <= LINE_LENGTH_RESET;
      line_count   <= LINE_COUNT_RESET;
      column_count <= '0;
      line_index   <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        window_regs[i] <= '0;
      end
    end else begin
      // output valid flag
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            pix_reg <= pixel;
            cur_col <= col_start;
            cur_row <= row_start;
            state   <= S_WIN;
          end
        end
        S_WIN: begin
          window_regs[0] <= window_regs[3];
          window_regs[1] <= window_regs[4];
          window_regs[2] <= window_regs[5];
          window_regs[3] <= top;
          window_regs[4] <= mid;
          window_regs[5] <= pix_reg;
          gx_reg  <= gx;
          gy_reg  <= gy;
          eof_reg <= last_pos;
          state <= produce ? S_SQ : S_IDLE;
        end
        S_SQ: begin
          sq_x  <= prod_x[SQ_W-1:0];
          sq_y  <= prod_y[SQ_W-1:0];
          state <= S_SUM;
        end
        S_SUM: begin
          if (sat) begin
            mag_reg <= MAG_MAX;
            state   <= S_OUT;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_status.done) begin
            mag_reg <= root;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            magnitude    <= mag_reg;
            end_of_frame <= eof_reg;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // frame position, a geometry register write restarts the frame
      if (cfg_restart) begin
        column_count <= '0;
        line_index   <= '0;
      end else if (state == S_WIN) begin
        if (col_inc >= eff_len) begin
          column_count <= '0;
          line_index   <= (row_inc >= {1'b0, eff_cnt}) ? '0 : row_inc[CNT_W-1:0];
        end else begin
          column_count <= col_inc[COL_W-1:0];
        end
      end
      // geometry registers
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_LENGTH: begin
            line_length <= cfg_data[LEN_W-1:0];
          end
          REG_LINE_COUNT: begin
            line_count <= cfg_data[CNT_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // checks
  `SEM_ASSERT_NOW(a_col_range, clk, rst, 1'b1, ({1'b0, column_count} < eff_len))
  `SEM_ASSERT_NOW(a_row_range, clk, rst, 1'b1, (line_index < eff_cnt))
  `SEM_ASSERT_NEXT(a_sat_skips_root, clk, rst, (state == S_SUM && sat), (state == S_OUT))
  `SEM_ASSERT_NEXT(a_load_shows, clk, rst, out_load, (out_valid && state == S_IDLE))

endmodule
`default_nettype wire

/* tb/tb.sv */
module tb;
  import sem_pkg::*;

  // unused register slots, writes there must leave the frame alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int unsigned RANDOM_PIXELS     = 1250;
  localparam int unsigned POST_DRAIN_CYCLES = 40;
  localparam int unsigned STUCK_LIMIT       = 3000;
  localparam int unsigned MAX_REPORTS       = 10;

  typedef struct {
    pix_t mag;
    logic eof;
  } mag_due_t;

  // running copy of the filter: line stores, window columns, frame position
  class edge_magnitude_tracker;
    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] cnt_reg;
    pix_t             line_a [MAX_LINE];
    pix_t             line_b [MAX_LINE];
    pix_t             col_m2 [3];
    pix_t             col_m1 [3];
    int unsigned      col;
    int unsigned      row;
    mag_due_t         mags_due[$];
    int unsigned      n_pixels;
    int unsigned      n_checked;
    int unsigned      n_saturated;
    int unsigned      n_zero;
    int unsigned      n_eof;
    int unsigned      errors;

    function void restart();
      len_reg = LINE_LENGTH_RESET;
      cnt_reg = LINE_COUNT_RESET;
      for (int i = 0; i < MAX_LINE; i++) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        col_m2[i] = '0;
        col_m1[i] = '0;
      end
      col = 0;
      row = 0;
      mags_due.delete();
    endfunction

    function void note_error(string msg);
      if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
      errors++;
    endfunction

    // geometry writes restart the frame, spare slots are ignored
    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_LENGTH: begin
          len_reg = data[LEN_W-1:0];
          col = 0;
          row = 0;
        end
        REG_LINE_COUNT: begin
          cnt_reg = data[CNT_W-1:0];
          col = 0;
          row = 0;
        end
        default: ;
      endcase
    endfunction

    function automatic int unsigned floor_root(int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 7; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // one pixel transfer: shift the window, emit a magnitude on interior positions
    function void take_pixel(pix_t p);
      int unsigned span;
      int unsigned depth;
      int unsigned c;
      int unsigned r;
      pix_t        top;
      pix_t        mid;
      int          w [9];
      int          gx;
      int          gy;
      int unsigned energy;
      mag_due_t    due;
      span  = (len_reg < MIN_LENGTH) ? 3 : ((len_reg > MAX_LINE) ? MAX_LINE : len_reg);
      depth = (cnt_reg < MIN_COUNT) ? 3 : cnt_reg;
      c = (col >= span) ? 0 : col;
      r = (row >= depth) ? 0 : row;
      n_pixels++;

      top = line_b[c];
      mid = line_a[c];
      line_b[c] = mid;
      line_a[c] = p;

      // row major window, oldest column first
      w[0] = int'(col_m2[0]); w[1] = int'(col_m1[0]); w[2] = int'(top);
      w[3] = int'(col_m2[1]); w[4] = int'(col_m1[1]); w[5] = int'(mid);
      w[6] = int'(col_m2[2]); w[7] = int'(col_m1[2]); w[8] = int'(p);
      col_m2 = col_m1;
      col_m1[0] = top;
      col_m1[1] = mid;
      col_m1[2] = p;

      if (r >= 2 && c >= 2) begin
        gx = (w[2] + 2 * w[5] + w[8]) - (w[0] + 2 * w[3] + w[6]);
        gy = (w[6] + 2 * w[7] + w[8]) - (w[0] + 2 * w[1] + w[2]);
        energy = gx * gx + gy * gy;
        due.mag = (energy >= 65536) ? MAG_MAX : pix_t'(floor_root(energy));
        due.eof = (r == depth - 1) && (c == span - 1);
        if (due.mag == MAG_MAX) n_saturated++;
        if (due.mag == '0) n_zero++;
        if (due.eof) n_eof++;
        mags_due.push_back(due);
      end

      // advance position, wrap at line and frame end
      c++;
      if (c >= span) begin
        c = 0;
        r++;
        if (r >= depth) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void check_result(pix_t mag, logic eof);
      mag_due_t want;
      if (mags_due.size() == 0) begin
        note_error($sformatf("unexpected result magnitude=%0d end_of_frame=%0b", mag, eof));
        return;
      end
      want = mags_due.pop_front();
      if (mag !== want.mag || eof !== want.eof)
        note_error($sformatf({"result %0d: expected magnitude=%0d end_of_frame=%0b, ",
                              "got magnitude=%0d end_of_frame=%0b"},
                             n_checked, want.mag, want.eof, mag, eof));
      n_checked++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel     = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      magnitude;
  logic                  end_of_frame;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  edge_magnitude_tracker trk;
  int unsigned           send_idle_pct = 0;
  int unsigned           stall_pct     = 0;
  int unsigned           n_writes      = 0;
  int unsigned           longest_line  = 0;
  pix_t                  last_pix      = '0;

  sobel_edge_magnitude u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .magnitude    (magnitude),
    .end_of_frame (end_of_frame),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // observe transfers and register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) trk.check_result(magnitude, end_of_frame);
      if (in_valid && in_ready) trk.take_pixel(pixel);
      if (cfg_we) trk.apply_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
    $display("tb failed");
    $finish;
  end

  task automatic send_pixel(input pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every magnitude is back, then let the pipe settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (trk.mags_due.size() != 0) @(posedge clk);
    repeat (POST_DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // mix of flat runs, hard edges, gentle texture and noise
  function automatic pix_t next_pixel();
    case ($urandom_range(3))
      0: ;
      1: last_pix = $urandom_range(1) ? 8'hFF : 8'h00;
      2: last_pix = pix_t'($urandom_range(148, 108));
      default: last_pix = pix_t'($urandom);
    endcase
    return last_pix;
  endfunction

  initial begin
    int unsigned           phase;
    int unsigned           random_sent;
    int unsigned           n;
    int unsigned           span;
    int unsigned           depth;
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] cnt_word;
    logic [CFG_DATA_W-1:0] next_len;
    logic [CFG_DATA_W-1:0] next_cnt;
    logic                  wr_len;
    logic                  wr_cnt;

    trk = new();
    trk.restart();
    len_word = CFG_DATA_W'(LINE_LENGTH_RESET);
    cnt_word = CFG_DATA_W'(LINE_COUNT_RESET);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest frame via out of range geometry
    write_reg(REG_LINE_LENGTH, 16'h0000);
    write_reg(REG_LINE_COUNT, 16'h0001);

    // saturating vertical edge, frame split by a spare register write
    send_pixel(8'h00); send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'h00);
    wait_drain();
    write_reg(REG_SPARE_3, 16'hFFFF);
    send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'hFF);
    send_pixel(8'hFF);

    // partial frame cut short by a geometry write, then a gentle ramp
    for (int k = 0; k < 4; k++) send_pixel(8'hFF);
    wait_drain();
    write_reg(REG_LINE_LENGTH, 16'h0002);
    len_word = 16'h0002;
    cnt_word = 16'h0001;
    for (int k = 0; k < 9; k++) send_pixel(pix_t'(4 * k));

    // random phases over several geometries and idle patterns
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      wait_drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2, 16'($urandom));

      wr_len = 1'b1;
      wr_cnt = 1'b1;
      case (phase)
        0: begin next_len = 16'd3;    next_cnt = 16'd3;    end
        1: begin next_len = 16'hFFFF; next_cnt = 16'd3;    end
        2: begin next_len = 16'd5;    next_cnt = 16'hFFFF; end
        3: begin next_len = 16'hF805; next_cnt = 16'h0000; end
        default: begin
          next_len = ($urandom_range(7) == 0) ? 16'($urandom_range(40))
                                              : 16'($urandom_range(12, 3));
          next_cnt = ($urandom_range(7) == 0) ? 16'($urandom_range(2))
                                              : 16'($urandom_range(6, 3));
          wr_len = ($urandom_range(4) != 0);
          wr_cnt = ($urandom_range(4) != 0);
        end
      endcase
      if (wr_len) begin
        write_reg(REG_LINE_LENGTH, next_len);
        len_word = next_len;
      end
      if (wr_cnt) begin
        write_reg(REG_LINE_COUNT, next_cnt);
        cnt_word = next_cnt;
      end

      span  = len_word[LEN_W-1:0];
      span  = (span < 3) ? 3 : ((span > MAX_LINE) ? MAX_LINE : span);
      depth = (cnt_word < 3) ? 3 : cnt_word;
      if (span > longest_line) longest_line = span;
      if (phase == 1) n = 300;
      else if (phase == 2) n = 200;
      else n = $urandom_range(3, 1) * span * depth + $urandom_range(span * depth - 1);
      if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;

      for (int unsigned i = 0; i < n; i++) begin
        // one pause mid phase until all magnitudes are back
        if (phase == 5 && i == n / 2) wait_drain();
        send_pixel(next_pixel());
      end
      random_sent += n;
      phase++;
    end

    // drain and let the pipe run empty
    in_valid <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    while (trk.mags_due.size() != 0) @(posedge clk);
    repeat (POST_DRAIN_CYCLES) @(posedge clk);
    if (trk.mags_due.size() != 0)
      trk.note_error($sformatf("%0d magnitudes never arrived", trk.mags_due.size()));

    $display("covered %0d pixels and %0d magnitudes (%0d saturated, %0d zero, %0d frame ends)",
             trk.n_pixels, trk.n_checked, trk.n_saturated, trk.n_zero, trk.n_eof);
    $display("over %0d phases with %0d register writes, longest line %0d, %0d mismatches",
             phase, n_writes, longest_line, trk.errors);
    if (trk.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
